// ===== design/gcdist_pkg.sv =====
package gcdist_pkg;

	localparam int MaxGenesDefault = 256;

	// item opcodes
	localparam logic [1:0] OP_LOAD_A  = 2'd0;
	localparam logic [1:0] OP_LOAD_B  = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	// register indexes
	localparam logic [1:0] REG_EXCESS   = 2'd0;
	localparam logic [1:0] REG_DISJOINT = 2'd1;
	localparam logic [1:0] REG_WEIGHT   = 2'd2;

	// reset values of the coefficients, Q8.8
	localparam logic [15:0] EXCESS_RESET   = 16'd256;
	localparam logic [15:0] DISJOINT_RESET = 16'd256;
	localparam logic [15:0] WEIGHT_RESET   = 16'd102;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_MATCH = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        gene_key;
		logic               gene_enabled;
		logic signed [31:0] gene_weight;
	} item_t;

	typedef struct packed {
		logic [31:0] distance;
		logic [8:0]  excess_count;
		logic [9:0]  disjoint_count;
		logic [8:0]  matching_count;
		logic [1:0]  status;
		logic        load_dropped;
	} result_t;

	typedef struct packed {
		logic [15:0] excess;
		logic [15:0] disjoint;
		logic [15:0] weight;
	} coef_t;

	typedef struct packed {
		logic [31:0]        key;
		logic               enabled;
		logic signed [31:0] weight;
	} gene_t;

endpackage

// ===== design/gcdist_cfg.sv =====
module gcdist_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output gcdist_pkg::coef_t   coef
);
	import gcdist_pkg::*;

	coef_t      coef_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign coef    = coef_q;

	// write the coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.excess   <= EXCESS_RESET;
			coef_q.disjoint <= DISJOINT_RESET;
			coef_q.weight   <= WEIGHT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_EXCESS:   coef_q.excess   <= pwdata[15:0];
				REG_DISJOINT: coef_q.disjoint <= pwdata[15:0];
				REG_WEIGHT:   coef_q.weight   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_EXCESS:   prdata = {16'd0, coef_q.excess};
			REG_DISJOINT: prdata = {16'd0, coef_q.disjoint};
			REG_WEIGHT:   prdata = {16'd0, coef_q.weight};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

// ===== design/gcdist_div.sv =====
module gcdist_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             ge;

	assign shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign quo     = quo_q;
	assign done    = done_q;

	// control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NUM_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: restoring shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

endmodule

// ===== design/genome_compatibility_distance.sv =====
// Loads (opcode 0/1) are taken in the idle state; busy stays low, one item per cycle.
// A compute item walks the lists one gene step at a time, each step a read (S_READ)
// and a compare (S_CMP), plus one closing read, then runs up to three multiply/divide
// terms through one shared bit-serial divider.
// The finish state S_FIN then registers the result and shows done for one cycle; no stall.
// Reset clears the lengths, drop flag and coefficients; gene memories need none.
module genome_compatibility_distance #(
	parameter int MAX_GENES = gcdist_pkg::MaxGenesDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  gcdist_pkg::item_t     item,
	output logic                  busy,
	output logic                  done,
	output gcdist_pkg::result_t   result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import gcdist_pkg::*;

	localparam int IDX_W = $clog2(MAX_GENES);
	localparam int LEN_W = $clog2(MAX_GENES + 1);
	localparam int CNT_W = LEN_W + 1;
	localparam int WS_W  = LEN_W + 33;
	localparam int PR_W  = WS_W + 16;
	localparam int DN_W  = PR_W - 8;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DIVGO = 3'd4;
	localparam logic [2:0] S_DIVWT = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	localparam logic [1:0] TERM_E = 2'd0;
	localparam logic [1:0] TERM_D = 2'd1;
	localparam logic [1:0] TERM_W = 2'd2;

	coef_t coef;

	gcdist_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.coef
	);

	logic [2:0]       state_q;
	logic [1:0]       term_q;
	logic [LEN_W-1:0] a_len_q, b_len_q, i_q, j_q;
	logic             drop_q;
	logic [CNT_W-1:0] excess_q, disjoint_q, matching_q;
	logic [WS_W-1:0]  wsum_q;
	logic [PR_W-1:0]  prod_q;
	logic [33:0]      acc_q;
	logic             done_q;
	result_t          result_q;

	gene_t mem_a [MAX_GENES];
	gene_t mem_b [MAX_GENES];
	gene_t rd_a_q, rd_b_q;

	logic             accept;
	logic             wr_a, wr_b;
	gene_t            new_gene;
	logic [LEN_W-1:0] maxlen;
	logic             a_vld, b_vld;
	logic signed [32:0] wdiff;
	logic [32:0]      wabs;
	logic [15:0]      mul_a;
	logic [WS_W-1:0]  mul_b;
	logic [DN_W-1:0]  div_num;
	logic [LEN_W-1:0] div_den;
	logic [DN_W-1:0]  div_quo;
	logic             div_done;
	logic             div_start;
	logic [31:0]      wsat;
	logic [CNT_W+9:0] ex_ext, dj_ext, mt_ext;

	assign busy     = state_q != S_IDLE;
	assign accept   = start && !busy;
	assign wr_a     = accept && item.opcode == OP_LOAD_A && a_len_q < LEN_W'(MAX_GENES);
	assign wr_b     = accept && item.opcode == OP_LOAD_B && b_len_q < LEN_W'(MAX_GENES);
	assign new_gene = '{key: item.gene_key, enabled: item.gene_enabled,
	                    weight: item.gene_weight};
	assign maxlen   = (a_len_q > b_len_q) ? a_len_q : b_len_q;
	assign a_vld    = i_q < a_len_q;
	assign b_vld    = j_q < b_len_q;
	assign wdiff    = {rd_a_q.weight[31], rd_a_q.weight} - {rd_b_q.weight[31], rd_b_q.weight};
	assign wabs     = wdiff[32] ? 33'(-wdiff) : 33'(wdiff);
	assign div_start = state_q == S_DIVGO;
	assign wsat     = (|div_quo[DN_W-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
	assign done     = done_q;
	assign result   = result_q;

	// gene memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (wr_a) mem_a[a_len_q[IDX_W-1:0]] <= new_gene;
		rd_a_q <= mem_a[i_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_b) mem_b[b_len_q[IDX_W-1:0]] <= new_gene;
		rd_b_q <= mem_b[j_q[IDX_W-1:0]];
	end

	// select multiplier operands for the current term
	always_comb begin
		unique case (term_q)
			TERM_E: begin
				mul_a = coef.excess;
				mul_b = {{(WS_W-CNT_W){1'b0}}, excess_q};
			end
			TERM_D: begin
				mul_a = coef.disjoint;
				mul_b = {{(WS_W-CNT_W){1'b0}}, disjoint_q};
			end
			default: begin
				mul_a = coef.weight;
				mul_b = wsum_q;
			end
		endcase
	end

	// scale numerator: x256 for gene fractions, /256 for the weight term
	always_comb begin
		if (term_q == TERM_W) begin
			div_num = prod_q[PR_W-1:8];
			div_den = matching_q[LEN_W-1:0];
		end else begin
			div_num = prod_q[DN_W-1:0] << 8;
			div_den = maxlen;
		end
	end

	gcdist_div #(.NUM_W(DN_W), .DEN_W(LEN_W)) u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.quo(div_quo), .done(div_done)
	);

	// sequencer and list length counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			term_q  <= TERM_E;
			a_len_q <= '0;
			b_len_q <= '0;
			drop_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.opcode)
							OP_LOAD_A: begin
								if (wr_a) a_len_q <= a_len_q + 1'b1;
								else drop_q <= 1'b1;
							end
							OP_LOAD_B: begin
								if (wr_b) b_len_q <= b_len_q + 1'b1;
								else drop_q <= 1'b1;
							end
							OP_COMPUTE: state_q <= S_READ;
							default: ;
						endcase
					end
				end
				S_READ: begin
					if (a_vld || b_vld) state_q <= S_CMP;
					else if (maxlen == '0) state_q <= S_FIN;
					else begin
						term_q  <= TERM_E;
						state_q <= S_MUL;
					end
				end
				S_CMP: state_q <= S_READ;
				S_MUL: state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIVWT;
				S_DIVWT: begin
					if (div_done) begin
						priority if (term_q == TERM_E) begin
							term_q  <= TERM_D;
							state_q <= S_MUL;
						end else if (term_q == TERM_D && matching_q != '0) begin
							term_q  <= TERM_W;
							state_q <= S_MUL;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					a_len_q <= '0;
					b_len_q <= '0;
					drop_q  <= 1'b0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// merge walk and term accumulation
	always_ff @(posedge clk) begin
		if (accept && item.opcode == OP_COMPUTE) begin
			i_q        <= '0;
			j_q        <= '0;
			excess_q   <= '0;
			disjoint_q <= '0;
			matching_q <= '0;
			wsum_q     <= '0;
			acc_q      <= '0;
		end else if (state_q == S_CMP) begin
			priority if (!b_vld) begin
				excess_q <= excess_q + 1'b1;
				i_q      <= i_q + 1'b1;
			end else if (!a_vld) begin
				excess_q <= excess_q + 1'b1;
				j_q      <= j_q + 1'b1;
			end else if (rd_a_q.key == rd_b_q.key) begin
				if (rd_a_q.enabled && rd_b_q.enabled) begin
					wsum_q     <= wsum_q + {{(WS_W-33){1'b0}}, wabs};
					matching_q <= matching_q + 1'b1;
				end
				i_q <= i_q + 1'b1;
				j_q <= j_q + 1'b1;
			end else if (rd_a_q.key < rd_b_q.key) begin
				disjoint_q <= disjoint_q + 1'b1;
				i_q        <= i_q + 1'b1;
			end else begin
				disjoint_q <= disjoint_q + 1'b1;
				j_q        <= j_q + 1'b1;
			end
		end else if (state_q == S_MUL) begin
			prod_q <= {{WS_W{1'b0}}, mul_a} * {{16{1'b0}}, mul_b};
		end else if (state_q == S_DIVWT && div_done) begin
			if (term_q == TERM_W) acc_q <= acc_q + {2'b00, wsat};
			else acc_q <= acc_q + 34'(div_quo);
		end
	end

	assign ex_ext = {{10{1'b0}}, excess_q};
	assign dj_ext = {{10{1'b0}}, disjoint_q};
	assign mt_ext = {{10{1'b0}}, matching_q};

	// capture the result
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			result_q.distance       <= (|acc_q[33:32]) ? 32'hFFFF_FFFF : acc_q[31:0];
			result_q.excess_count   <= ex_ext[8:0];
			result_q.disjoint_count <= dj_ext[9:0];
			result_q.matching_count <= mt_ext[8:0];
			result_q.load_dropped   <= drop_q;
			if (maxlen == '0) result_q.status <= STAT_EMPTY;
			else if (matching_q == '0) result_q.status <= STAT_NO_MATCH;
			else result_q.status <= STAT_OK;
		end
	end

	// lists are empty after every result
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (a_len_q == '0 && b_len_q == '0 && !drop_q))
		else $error("lists not cleared after result");

	// walk indexes never pass their list ends
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (i_q <= a_len_q && j_q <= b_len_q))
		else $error("walk index beyond list");

	// empty lists give a zero distance
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_EMPTY) |-> (result.distance == 32'd0))
		else $error("empty lists with nonzero distance");

	// the divider reports completion for a single cycle
	a_div_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |=> !div_done)
		else $error("divider done held");

endmodule
